// ===== sv/eaod_pkg.sv =====
package eaod_pkg;

  localparam int PIX_W   = 8;
  localparam int LINE_W  = 16;
  localparam int TIDX_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LWIDTH_W   = 13;

  // Request kinds
  localparam logic FUNC_TABLE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Pixel modes; the unused code behaves as eight-bit black
  localparam logic [1:0] MODE_ONE_BIT = 2'd0;
  localparam logic [1:0] MODE_GRAY    = 2'd1;
  localparam logic [1:0] MODE_BLACK   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_MODE    = 3'd0,
    CFG_LINE_WIDTH    = 3'd1,
    CFG_TOP_LINE      = 3'd2,
    CFG_BOTTOM_LINE   = 3'd3,
    CFG_INVERT_OUTPUT = 3'd4
  } cfg_idx_t;

  localparam logic [PIX_W-1:0] LUM_LO      = 8'd56;
  localparam logic [PIX_W-1:0] LUM_HI      = 8'd199;
  localparam logic [PIX_W-1:0] MID_LEVEL   = 8'd127;
  localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd0;
  localparam logic [PIX_W-1:0] BLACK_LEVEL = 8'd255;
  localparam logic [PIX_W-1:0] MSB_DOT     = 8'h80;

  function automatic logic [PIX_W-1:0] convert_pixel(
    input logic [1:0]       mode,
    input logic [PIX_W-1:0] p,
    input logic             blank
  );
    logic [PIX_W-1:0] v;
    case (mode)
      MODE_ONE_BIT: v = p[0] ? BLACK_LEVEL : WHITE_LEVEL;
      MODE_GRAY: begin
        if (p < LUM_LO)      v = BLACK_LEVEL;
        else if (p > LUM_HI) v = WHITE_LEVEL;
        else                 v = BLACK_LEVEL - p;
      end
      default: begin
        if (p < LUM_LO)      v = WHITE_LEVEL;
        else if (p > LUM_HI) v = BLACK_LEVEL;
        else                 v = p;
      end
    endcase
    return blank ? WHITE_LEVEL : v;
  endfunction

  function automatic logic is_pure(input logic [PIX_W-1:0] v);
    return (v == WHITE_LEVEL) || (v == BLACK_LEVEL);
  endfunction

endpackage

// ===== sv/eaod_if.sv =====
interface eaod_in_if import eaod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [TIDX_W-1:0] table_index;
  logic [PIX_W-1:0]  table_value;
  logic [LINE_W-1:0] line_index;
  logic [PIX_W-1:0]  pixel;
  logic              blank;

  modport source (output valid, func, table_index, table_value, line_index, pixel, blank,
                  input ready);
  modport sink (input valid, func, table_index, table_value, line_index, pixel, blank,
                output ready);
endinterface

interface eaod_out_if import eaod_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_byte;
  logic             last_of_line;

  modport source (output valid, out_byte, last_of_line, input ready);
  modport sink (input valid, out_byte, last_of_line, output ready);
endinterface

interface eaod_cfg_if import eaod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/edge_aware_ordered_dither.sv =====
// Edge-aware ordered dither. One request per clock when in_ch.ready is high: a
// pixel request converts the pixel to a black level, stores it in a ring of
// LINE_SLOTS line memories and classifies the same column of the previous line
// against its left, right, above and below neighbours and the 16x16 dither
// table; a table request (func 0) loads one threshold. Dots are packed
// first-dot-in-bit-7 and a byte leaves on out_ch through the output queue (full
// byte or line end, lines top_line+1 to bottom_line+1 only). The sustained rate
// is one request per cycle while the queue has room: each line slot is split
// into even and odd column banks with two read ports each, so the three reads of
// the previous line and the read of the line before it are served at once while
// the new pixel is written. A three-entry output queue absorbs back-pressure;
// in_ch.ready drops only when that queue could overflow or while the line
// memories are cleared after reset, one bank row per cycle over (MAX_COLS+1)/2
// rows (2048 at the default MAX_COLS). cfg_ch is always ready; the user must
// send writes only while no request is in flight; the block does not enforce it.
module edge_aware_ordered_dither import eaod_pkg::*; #(
  parameter int MAX_COLS   = 4096,
  parameter int LINE_SLOTS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  eaod_in_if.sink    in_ch,
  eaod_out_if.source out_ch,
  eaod_cfg_if.sink   cfg_ch
);

  localparam int XW          = $clog2(MAX_COLS);
  localparam int BANK_DEPTH  = (MAX_COLS + 1) / 2;
  localparam int BAW         = $clog2(BANK_DEPTH);
  localparam int SW          = $clog2(LINE_SLOTS);
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP       = (2**RECIP_SHIFT + LINE_SLOTS - 1) / LINE_SLOTS;
  localparam int WM1_RST     = ((1024 > MAX_COLS) ? MAX_COLS : 1024) - 1;
  localparam int OQ_DEPTH    = 3;
  localparam int OQ_PW       = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic [XW-1:0]     x;
    logic              last;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] q;
    logic              area;
    logic [PIX_W-1:0]  nv;
  } s1_t;

  typedef struct packed {
    logic             valid;
    logic [SW-1:0]    slot;
    logic [XW-1:0]    x;
    logic [PIX_W-1:0] val;
  } fwd_t;

  typedef struct packed {
    logic [PIX_W-1:0] dots;
    logic             last_flag;
  } oq_item_t;

  // ---------------------------------------------------------------------------
  // Configuration registers; the width is kept as its clamped last column.
  // ---------------------------------------------------------------------------
  logic [1:0]        pixel_mode_r;
  logic [XW-1:0]     wm1_r;
  logic [LINE_W-1:0] top_r;
  logic [LINE_W-1:0] bottom_r;
  logic              invert_r;
  logic [XW-1:0]     wm1_cfg;
  int unsigned       lw;

  assign cfg_ch.ready = 1'b1;

  // Clamp a width of zero to one and anything past MAX_COLS to MAX_COLS.
  always_comb begin
    lw = 32'(cfg_ch.data[LWIDTH_W-1:0]);
    if (lw == 0)              wm1_cfg = '0;
    else if (lw > MAX_COLS)   wm1_cfg = XW'(MAX_COLS - 1);
    else                      wm1_cfg = XW'(lw - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r <= MODE_GRAY;
      wm1_r        <= XW'(WM1_RST);
      top_r        <= '0;
      bottom_r     <= '1;
      invert_r     <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PIXEL_MODE:    pixel_mode_r <= cfg_ch.data[1:0];
        CFG_LINE_WIDTH:    wm1_r        <= wm1_cfg;
        CFG_TOP_LINE:      top_r        <= cfg_ch.data;
        CFG_BOTTOM_LINE:   bottom_r     <= cfg_ch.data;
        CFG_INVERT_OUTPUT: invert_r     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass over the line memories after reset.
  // ---------------------------------------------------------------------------
  logic           clearing_r;
  logic [BAW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == BAW'(BANK_DEPTH - 1)) clearing_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept, column tracking, memory read issue.
  // ---------------------------------------------------------------------------
  logic              in_acc, pix_acc, tbl_acc;
  logic [XW-1:0]     column_r;
  logic [XW-1:0]     x0;
  logic              last0;
  logic [LINE_W-1:0] line0;
  logic [15:0]       x0_w;
  logic              area0;
  logic [33:0]       prod0;
  logic [BAW-1:0]    h0, hp1, hm1;
  logic              s1_valid_r;
  logic [OQ_PW-1:0]  occ_r;

  // Hold off new requests during the clearing pass, and otherwise only while the
  // output queue could not take a byte from every request already past stage 0.
  assign in_ch.ready = !clearing_r &&
                       ((3'(occ_r) + 3'(s1_valid_r)) < 3'(OQ_DEPTH));

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign pix_acc = in_acc && (in_ch.func == FUNC_PIXEL);
  assign tbl_acc = in_acc && (in_ch.func == FUNC_TABLE);

  always_comb begin
    // A column left past a lowered width counts as the last column.
    x0    = (column_r > wm1_r) ? wm1_r : column_r;
    last0 = (x0 == wm1_r);
    line0 = in_ch.line_index;
    x0_w  = 16'(x0);
    area0 = (line0 > top_r) && ({1'b0, line0} <= ({1'b0, bottom_r} + 17'd1));
    // Quotient of line / LINE_SLOTS by reciprocal; the slot follows in stage 1.
    prod0 = 34'(line0) * 34'(RECIP);
    h0    = BAW'(x0 >> 1);
    hp1   = h0 + 1'b1;
    hm1   = h0 - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
    end else if (pix_acc) begin
      column_r <= last0 ? '0 : x0 + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Dither table: written by table requests, read for every pixel request.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] tbl_rd;

  eaod_ram #(
    .WIDTH (PIX_W),
    .DEPTH (256)
  ) u_table (
    .clk     (clk),
    .we      (tbl_acc),
    .waddr   (in_ch.table_index),
    .wdata   (in_ch.table_value),
    .raddr_a ({line0[3:0], x0_w[3:0]}),
    .raddr_b ({line0[3:0], x0_w[3:0]}),
    .rdata_a (tbl_rd),
    .rdata_b ()
  );

  // ---------------------------------------------------------------------------
  // Stage 1 registers.
  // ---------------------------------------------------------------------------
  s1_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= pix_acc;
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_r.x    <= x0;
      s1_r.last <= last0;
      s1_r.line <= line0;
      s1_r.q    <= prod0[RECIP_SHIFT +: LINE_W];
      s1_r.area <= area0;
      s1_r.nv   <= convert_pixel(pixel_mode_r, in_ch.pixel, in_ch.blank);
    end
  end

  // ---------------------------------------------------------------------------
  // Line memories: LINE_SLOTS slots, each as even and odd column banks.
  // Even bank reads h and h+1, odd bank reads h and h-1, which together cover
  // columns x-1, x and x+1 of any slot.
  // ---------------------------------------------------------------------------
  logic [SW-1:0]    sn, sc, sp;
  logic [17:0]      sn_full;
  logic [PIX_W-1:0] rd_a [LINE_SLOTS][2];
  logic [PIX_W-1:0] rd_b [LINE_SLOTS][2];
  logic [BAW-1:0]   waddr;
  logic [PIX_W-1:0] wdata;

  always_comb begin
    sn_full = 18'(s1_r.line) - 18'(s1_r.q) * 18'(LINE_SLOTS);
    sn      = sn_full[SW-1:0];
    sc      = (sn == '0) ? SW'(LINE_SLOTS - 1) : SW'(sn - 1'b1);
    sp      = (sc == '0) ? SW'(LINE_SLOTS - 1) : SW'(sc - 1'b1);
    waddr   = clearing_r ? clr_addr_r : BAW'(s1_r.x >> 1);
    wdata   = clearing_r ? WHITE_LEVEL : s1_r.nv;
  end

  for (genvar s = 0; s < LINE_SLOTS; s++) begin : g_slot
    for (genvar b = 0; b < 2; b++) begin : g_bank
      logic we;
      assign we = clearing_r ||
                  (s1_valid_r && (sn == SW'(s)) && (s1_r.x[0] == 1'(b)));
      eaod_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_DEPTH)
      ) u_line (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (h0),
        .raddr_b ((b == 0) ? hp1 : hm1),
        .rdata_a (rd_a[s][b]),
        .rdata_b (rd_b[s][b])
      );
    end
  end

  // Capture this cycle's pixel write; the request now being read sees it
  // next cycle through the forward path, since the memory returns old data.
  fwd_t fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r.valid <= 1'b0;
    end else begin
      fwd_r.valid <= s1_valid_r;
    end
    fwd_r.slot <= sn;
    fwd_r.x    <= s1_r.x;
    fwd_r.val  <= s1_r.nv;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: classify, pack, push.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] cur, left, right, prev;
  logic [XW:0]      xe, fe;
  logic             neigh_pure, black, emit;
  logic [PIX_W-1:0] pack_byte_r, pack_byte_nxt, marked;
  logic [2:0]       pack_cnt_r, pack_cnt_nxt;
  oq_item_t         push_item;

  always_comb begin
    cur   = s1_r.x[0] ? rd_a[sc][1] : rd_a[sc][0];
    left  = s1_r.x[0] ? rd_a[sc][0] : rd_b[sc][1];
    right = s1_r.x[0] ? rd_b[sc][0] : rd_a[sc][1];
    prev  = s1_r.x[0] ? rd_a[sp][1] : rd_a[sp][0];

    xe = {1'b0, s1_r.x};
    fe = {1'b0, fwd_r.x};
    if (fwd_r.valid && (fwd_r.slot == sc)) begin
      if (fe == xe)         cur   = fwd_r.val;
      if ((fe + 1'b1) == xe) left  = fwd_r.val;
      if (fe == (xe + 1'b1)) right = fwd_r.val;
    end
    if (fwd_r.valid && (fwd_r.slot == sp) && (fe == xe)) prev = fwd_r.val;

    // Snap to a hard threshold next to a pure neighbour, else use the table.
    neigh_pure = ((s1_r.x != '0) && is_pure(left)) ||
                 (!s1_r.last && is_pure(right)) ||
                 is_pure(prev) || is_pure(s1_r.nv);

    if (cur == WHITE_LEVEL)      black = 1'b0;
    else if (cur == BLACK_LEVEL) black = 1'b1;
    else if (neigh_pure)         black = (cur > MID_LEVEL);
    else                         black = (cur > tbl_rd);

    marked = pack_byte_r | (black ? (MSB_DOT >> pack_cnt_r) : WHITE_LEVEL);

    emit               = s1_valid_r && s1_r.area && ((pack_cnt_r == 3'd7) || s1_r.last);
    push_item.dots     = invert_r ? ~marked : marked;
    push_item.last_flag = s1_r.last;

    pack_byte_nxt = pack_byte_r;
    pack_cnt_nxt  = pack_cnt_r;
    if (s1_valid_r) begin
      if (emit || s1_r.last) begin
        // Drop the partial byte at line end and after each full byte.
        pack_byte_nxt = '0;
        pack_cnt_nxt  = '0;
      end else if (s1_r.area) begin
        pack_byte_nxt = marked;
        pack_cnt_nxt  = pack_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_byte_r <= '0;
      pack_cnt_r  <= '0;
    end else begin
      pack_byte_r <= pack_byte_nxt;
      pack_cnt_r  <= pack_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue.
  // ---------------------------------------------------------------------------
  oq_item_t         oq_r [OQ_DEPTH];
  logic [OQ_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic             pop;

  assign out_ch.valid        = (occ_r != '0);
  assign out_ch.out_byte     = oq_r[rd_ptr_r].dots;
  assign out_ch.last_of_line = oq_r[rd_ptr_r].last_flag;
  assign pop                 = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (emit) oq_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      if (emit) wr_ptr_r <= (wr_ptr_r == OQ_PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == OQ_PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      occ_r <= occ_r + OQ_PW'(emit) - OQ_PW'(pop);
    end
  end

endmodule

// ===== sv/eaod_ram.sv =====
module eaod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== verif/tb_edge_aware_ordered_dither.sv =====
`timescale 1ns / 100ps

module tb_edge_aware_ordered_dither;
  import eaod_pkg::*;

  localparam int MAX_W         = 4096;
  localparam int LINE_SLOTS    = 4;
  localparam int RANDOM_ITEMS  = 800;
  // Settle time after the last expected byte: table writes or pixels outside the
  // area leave no byte, so they need time to finish inside the block.
  localparam int SETTLE_CYCLES = 8;
  // Slowest correct run: the memory clear after reset, about 1300 requests each
  // slowed by a random send gap and a random receive stall, plus drain time at
  // each phase change. Take it several times over.
  localparam int CYCLE_LIMIT   = 100000;

  typedef struct {
    logic              func;
    logic [TIDX_W-1:0] table_index;
    logic [PIX_W-1:0]  table_value;
    logic [LINE_W-1:0] line_index;
    logic [PIX_W-1:0]  pixel;
    logic              blank;
  } dither_req_t;

  typedef struct {
    logic [PIX_W-1:0] dots;
    logic             last;
  } dot_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  eaod_in_if  in_ch();
  eaod_out_if out_ch();
  eaod_cfg_if cfg_ch();

  edge_aware_ordered_dither dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the registers, at their reset values.
  logic [1:0]        cfg_mode   = MODE_GRAY;
  logic [12:0]       cfg_width  = 13'd1024;
  logic [LINE_W-1:0] cfg_top    = 16'd0;
  logic [LINE_W-1:0] cfg_bottom = 16'hFFFF;
  logic              cfg_invert = 1'b0;

  // Shadow copy of the line stores, dither table and packing state.
  logic [PIX_W-1:0] level_rows [LINE_SLOTS*MAX_W];
  logic [PIX_W-1:0] thresholds [256];
  int unsigned      col_pos = 0;
  logic [PIX_W-1:0] dot_acc = '0;
  int unsigned      dot_cnt = 0;

  dither_req_t dither_reqs[$];     // requests waiting for the driver
  dot_byte_t   expected_bytes[$];  // bytes predicted, not yet seen
  dither_req_t held_req;           // request now on in_ch
  logic        req_held = 1'b0;

  int gap_left    = 0;
  int stall_left  = 0;
  bit quiet       = 1'b0;  // no idling on either side
  int mismatches  = 0;
  int queued_total = 0;
  int cycles      = 0;

  function automatic logic saturated(input logic [PIX_W-1:0] v);
    return (v == WHITE_LEVEL) || (v == BLACK_LEVEL);
  endfunction

  // Black level of a raw pixel under the current mode.
  function automatic logic [PIX_W-1:0] black_level(input logic [PIX_W-1:0] p,
                                                   input logic blank);
    logic [PIX_W-1:0] v;
    if (blank) begin
      v = WHITE_LEVEL;
    end else if (cfg_mode == MODE_ONE_BIT) begin
      v = p[0] ? BLACK_LEVEL : WHITE_LEVEL;
    end else if (cfg_mode == MODE_GRAY) begin
      if (p < LUM_LO) v = BLACK_LEVEL;
      else if (p > LUM_HI) v = WHITE_LEVEL;
      else v = BLACK_LEVEL - p;
    end else begin
      // mode 3 falls in here too: it acts as eight-bit black
      if (p < LUM_LO) v = WHITE_LEVEL;
      else if (p > LUM_HI) v = BLACK_LEVEL;
      else v = p;
    end
    return v;
  endfunction

  // Apply one accepted request to the shadow state and queue the byte it
  // completes, if any.
  function automatic void pack_dots(input dither_req_t r);
    int unsigned w, x, ln, row_n, row_c, row_p;
    logic [PIX_W-1:0] nv, cur;
    logic at_end, black, near_sat;
    dot_byte_t done;
    if (r.func == FUNC_TABLE) begin
      thresholds[r.table_index] = r.table_value;
      return;
    end
    w = cfg_width;
    if (w == 0) w = 1;
    else if (w > MAX_W) w = MAX_W;
    // a column left past a lowered width counts as the last column
    x = (col_pos >= w) ? w - 1 : col_pos;
    at_end = (x == w - 1);
    ln = r.line_index;
    row_n = (ln % LINE_SLOTS) * MAX_W;
    row_c = ((ln + LINE_SLOTS - 1) % LINE_SLOTS) * MAX_W;
    row_p = ((ln + LINE_SLOTS - 2) % LINE_SLOTS) * MAX_W;
    nv = black_level(r.pixel, r.blank);
    level_rows[row_n + x] = nv;
    if (ln >= cfg_top + 1 && ln <= cfg_bottom + 1) begin
      cur = level_rows[row_c + x];
      near_sat = saturated(level_rows[row_p + x]) || saturated(nv);
      if (x > 0 && saturated(level_rows[row_c + x - 1])) near_sat = 1'b1;
      if (!at_end && saturated(level_rows[row_c + x + 1])) near_sat = 1'b1;
      if (cur == WHITE_LEVEL) black = 1'b0;
      else if (cur == BLACK_LEVEL) black = 1'b1;
      else if (near_sat) black = cur > MID_LEVEL;
      else black = cur > thresholds[(ln % 16) * 16 + (x % 16)];
      if (black) dot_acc = dot_acc | (MSB_DOT >> dot_cnt);
      dot_cnt++;
      if (dot_cnt == 8 || at_end) begin
        done.dots = cfg_invert ? ~dot_acc : dot_acc;
        done.last = at_end;
        expected_bytes.push_back(done);
        dot_acc = '0;
        dot_cnt = 0;
      end
    end
    if (at_end) begin
      col_pos = 0;
      dot_acc = '0;
      dot_cnt = 0;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic void queue_pixel(input logic [LINE_W-1:0] ln,
                                      input logic [PIX_W-1:0] pix, input logic blank);
    dither_req_t r;
    r.func        = FUNC_PIXEL;
    r.table_index = TIDX_W'($urandom);
    r.table_value = PIX_W'($urandom);
    r.line_index  = ln;
    r.pixel       = pix;
    r.blank       = blank;
    dither_reqs.push_back(r);
    queued_total++;
  endfunction

  function automatic void queue_table(input logic [TIDX_W-1:0] idx,
                                      input logic [PIX_W-1:0] val);
    dither_req_t r;
    r.func        = FUNC_TABLE;
    r.table_index = idx;
    r.table_value = val;
    r.line_index  = LINE_W'($urandom);
    r.pixel       = PIX_W'($urandom);
    r.blank       = 1'($urandom);
    dither_reqs.push_back(r);
    queued_total++;
  endfunction

  // Mostly mid levels so the table path is reached; some clamped and pure.
  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] p;
    case ($urandom_range(0, 9))
      0: p = PIX_W'($urandom_range(0, 55));
      1: p = PIX_W'($urandom_range(200, 255));
      2: begin
        case ($urandom_range(0, 5))
          0: p = 8'd0;
          1: p = 8'd255;
          2: p = LUM_LO - 1;
          3: p = LUM_LO;
          4: p = LUM_HI;
          default: p = LUM_HI + 1;
        endcase
      end
      default: p = PIX_W'($urandom_range(56, 199));
    endcase
    return p;
  endfunction

  // One line of pixels with a few table writes, blanks and stray line numbers.
  function automatic void queue_line(input logic [LINE_W-1:0] ln, input int count);
    logic [LINE_W-1:0] this_line;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) queue_table(TIDX_W'($urandom), PIX_W'($urandom));
      this_line = ($urandom_range(0, 49) == 0) ? LINE_W'($urandom) : ln;
      queue_pixel(this_line, random_pixel(), $urandom_range(0, 15) == 0);
    end
  endfunction

  // Hold until every request is taken and every byte is back, then let
  // requests that leave no byte finish inside the block.
  task automatic wait_drained();
    while (dither_reqs.size() != 0 || req_held) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_PIXEL_MODE:    cfg_mode   = data[1:0];
      CFG_LINE_WIDTH:    cfg_width  = data[12:0];
      CFG_TOP_LINE:      cfg_top    = data;
      CFG_BOTTOM_LINE:   cfg_bottom = data;
      CFG_INVERT_OUTPUT: cfg_invert = data[0];
      default: ;
    endcase
  endtask

  // Drain, then write every register; unused upper bits carry noise.
  task automatic apply_setting(input logic [1:0] mode, input logic [12:0] width,
                               input logic [LINE_W-1:0] top,
                               input logic [LINE_W-1:0] bottom, input logic inv);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    wait_drained();
    write_reg(CFG_PIXEL_MODE, {junk[15:2], mode});
    write_reg(CFG_LINE_WIDTH, {junk[15:13], width});
    write_reg(CFG_TOP_LINE, top);
    write_reg(CFG_BOTTOM_LINE, bottom);
    write_reg(CFG_INVERT_OUTPUT, {junk[14:0], inv});
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic [12:0] width,
                           input logic [LINE_W-1:0] top, input logic [LINE_W-1:0] bottom,
                           input logic inv, input logic [LINE_W-1:0] first_line,
                           input int n_lines, input int tail);
    int eff;
    logic [LINE_W-1:0] ln;
    apply_setting(mode, width, top, bottom, inv);
    eff = (width == 0) ? 1 : ((width > MAX_W) ? MAX_W : width);
    if (tail >= eff) tail = eff - 1;
    ln = first_line;
    repeat (n_lines) begin
      queue_line(ln, eff);
      ln++;
    end
    // a partial line leaves the column mid-line for the next setting
    queue_line(ln, tail);
  endtask

  task automatic random_phase();
    logic [1:0] mode;
    logic [12:0] width;
    logic [LINE_W-1:0] first, top, bottom;
    int eff, n_lines, tail;
    mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: width = 13'd0;
      1: width = 13'd1;
      2: width = 13'($urandom_range(2, 8));
      8: width = 13'(8 * $urandom_range(1, 3));
      9: width = 13'($urandom_range(MAX_W + 1, 8191));
      default: width = 13'($urandom_range(9, 40));
    endcase
    eff = (width == 0) ? 1 : ((width > MAX_W) ? MAX_W : width);
    first = LINE_W'($urandom);
    if (eff > 64) begin
      // wide settings only see a partial line
      n_lines = 0;
      tail = $urandom_range(1, 60);
    end else begin
      n_lines = 1 + $urandom_range(10, 50) / eff;
      tail = ($urandom_range(0, 2) == 0) ? $urandom_range(0, eff - 1) : 0;
    end
    case ($urandom_range(0, 5))
      3: begin
        top = first;
        bottom = first + LINE_W'(n_lines) - 16'd2;
      end
      4: begin
        top = LINE_W'($urandom);
        bottom = LINE_W'($urandom);
      end
      5: begin
        top = first + 16'd1;
        bottom = 16'hFFFF;
      end
      default: begin
        top = 16'd0;
        bottom = 16'hFFFF;
      end
    endcase
    run_phase(mode, width, top, bottom, 1'($urandom), first, n_lines, tail);
  endtask

  // Driver: present queued requests, advance on each accept, and drop valid
  // for short random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        pack_dots(held_req);
        req_held = 1'b0;
      end
      if (gap_left != 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (dither_reqs.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= $urandom_range(0, 2);
      end else if (dither_reqs.size() != 0) begin
        held_req = dither_reqs.pop_front();
        req_held = 1'b1;
        in_ch.valid       <= 1'b1;
        in_ch.func        <= held_req.func;
        in_ch.table_index <= held_req.table_index;
        in_ch.table_value <= held_req.table_value;
        in_ch.line_index  <= held_req.line_index;
        in_ch.pixel       <= held_req.pixel;
        in_ch.blank       <= held_req.blank;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted byte with the oldest prediction and stall
  // the output in short random bursts.
  always @(posedge clk) begin
    dot_byte_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                   $time, out_ch.out_byte, out_ch.last_of_line);
        end else begin
          want = expected_bytes.pop_front();
          if (want.dots !== out_ch.out_byte || want.last !== out_ch.last_of_line) begin
            mismatches++;
            $display("%0t: out_byte expected %02h actual %02h, last expected %0b actual %0b",
                     $time, want.dots, out_ch.out_byte, want.last, out_ch.last_of_line);
          end
        end
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("edge_aware_ordered_dither verification failed");
      $finish;
    end
  end

  initial begin
    int rand_start;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_PIXEL;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    in_ch.line_index  = '0;
    in_ch.pixel       = '0;
    in_ch.blank       = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_PIXEL_MODE;
    cfg_ch.data       = '0;
    for (int i = 0; i < LINE_SLOTS * MAX_W; i++) level_rows[i] = WHITE_LEVEL;
    for (int i = 0; i < 256; i++) thresholds[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Load the whole dither table first so no lookup hits an unwritten entry.
    for (int i = 0; i < 256; i++)
      queue_table(TIDX_W'(i), (i == 0) ? 8'd0 : (i == 255) ? 8'd255 : PIX_W'($urandom));

    // Directed: grayscale, 8 wide, full area.
    apply_setting(MODE_GRAY, 13'd8, 16'd0, 16'hFFFF, 1'b0);
    // Line 0 is above the area: stored, no byte. Walk the clamp edges.
    queue_pixel(16'd0, 8'd0, 1'b0);
    queue_pixel(16'd0, LUM_LO - 1, 1'b0);
    queue_pixel(16'd0, LUM_LO, 1'b0);
    queue_pixel(16'd0, 8'd57, 1'b0);
    queue_pixel(16'd0, MID_LEVEL, 1'b0);
    queue_pixel(16'd0, MID_LEVEL + 1, 1'b0);
    queue_pixel(16'd0, LUM_HI, 1'b0);
    queue_pixel(16'd0, LUM_HI + 1, 1'b0);
    // Line 1 classifies line 0; rewrite the table entry the next pixel reads.
    queue_pixel(16'd1, 8'd255, 1'b0);
    queue_pixel(16'd1, 8'd100, 1'b0);
    queue_pixel(16'd1, 8'd100, 1'b0);
    queue_pixel(16'd1, 8'd100, 1'b0);
    queue_table(8'h14, 8'd90);
    queue_pixel(16'd1, 8'd100, 1'b0);
    queue_pixel(16'd1, 8'd150, 1'b0);
    queue_pixel(16'd1, 8'd60, 1'b0);
    queue_pixel(16'd1, 8'hA5, 1'b1);
    // Change line number mid-line.
    queue_pixel(16'd2, 8'd30, 1'b0);
    queue_pixel(16'd2, 8'd120, 1'b0);
    queue_pixel(16'd2, 8'd230, 1'b0);
    queue_pixel(16'd7, 8'd90, 1'b0);
    queue_pixel(16'd7, 8'd140, 1'b0);
    queue_pixel(16'd7, 8'd10, 1'b0);
    queue_pixel(16'd7, 8'd180, 1'b0);
    queue_pixel(16'd7, LUM_HI, 1'b0);

    // Register extremes. Every phase change drains first, so the sender
    // pauses until all bytes are back.
    run_phase(MODE_ONE_BIT, 13'd0, 16'd0, 16'hFFFF, 1'b1, 16'd5, 12, 0);
    run_phase(MODE_BLACK, 13'd8191, 16'd0, 16'hFFFF, 1'b0, 16'd40, 0, 40);
    // Width drops under the column left behind; lines wrap past 65535.
    run_phase(2'd3, 13'd5, 16'd0, 16'hFFFF, 1'b1, 16'hFFFE, 4, 2);
    run_phase(MODE_BLACK, 13'd7, 16'hFFFF, 16'hFFFF, 1'b0, 16'd100, 3, 0);
    run_phase(MODE_GRAY, 13'd12, 16'd0, 16'd0, 1'b1, 16'd0, 4, 0);

    // Random settings and lines; the last fifth runs without idling.
    rand_start = queued_total;
    while (queued_total - rand_start < RANDOM_ITEMS) begin
      if (queued_total - rand_start > RANDOM_ITEMS * 4 / 5) quiet = 1'b1;
      random_phase();
    end

    wait_drained();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("edge_aware_ordered_dither verification clean");
    end else begin
      $display("edge_aware_ordered_dither verification failed");
    end
    $finish;
  end

endmodule
